FILE: rtl/wbr_pkg.sv
// Shared types and constants for the write buffer in-order release unit.
package wbr_pkg;

   // Mark store geometry
   localparam int SLOT_COUNT = 256;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Field widths
   localparam int SLOT_W  = 16;
   localparam int LEN_W   = 9;
   localparam int PTR_W   = 32;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One queued run
   typedef struct packed {
      logic [SLOT_W-1:0] start_slot;
      logic [LEN_W-1:0]  run_length;
      logic [PTR_W-1:0]  producer_limit;
      logic              len_zero;
   } item_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

FILE: rtl/write_buffer_in_order_release_unit.sv
// With the back end idle, an out-of-order run of L slots is marked in ST_MARK, an in-order
// run releases slots in ST_SCAN, and ST_RESULT then loads the result and raises rsp_valid.
// The back end takes one run at a time while a two-entry queue keeps taking beats
// meanwhile; a stalled result holds the back end.
// Reset clears the queue, the release pointer and the result valid bit, then a pass
// over all 256 slots clears the done marks before the first run is taken.
module write_buffer_in_order_release_unit import wbr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SLOT_W-1:0] req_start_slot,
   input  logic [LEN_W-1:0]  req_run_length,
   input  logic [PTR_W-1:0]  req_producer_limit,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PTR_W-1:0]  rsp_release_pointer,
   output logic              rsp_advanced,
   output logic              rsp_double_mark
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Accept and queue run beats
   wbr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_slot     (req_start_slot),
      .req_run_length     (req_run_length),
      .req_producer_limit (req_producer_limit),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   // Mark, scan and release
   wbr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_release_pointer (rsp_release_pointer),
      .rsp_advanced        (rsp_advanced),
      .rsp_double_mark     (rsp_double_mark)
   );

   // Back end only pops a queued run
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");

   // One run in flight: no pop in the cycle after a pop
   assert property (@(posedge clock) disable iff (reset) q_pop |=> !q_pop)
      else $error("back end took two runs back to back");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

FILE: rtl/wbr_front.sv
// Front end: accepts run beats, tags empty runs and queues them for the back end.
module wbr_front import wbr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SLOT_W-1:0] req_start_slot,
   input  logic [LEN_W-1:0]  req_run_length,
   input  logic [PTR_W-1:0]  req_producer_limit,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);

   item_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   item_type          new_item;

   // Classify the incoming beat
   always_comb begin
      new_item.start_slot     = req_start_slot;
      new_item.run_length     = req_run_length;
      new_item.producer_limit = req_producer_limit;
      new_item.len_zero       = (req_run_length == '0);
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entries_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !q_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (!push && q_pop) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: rtl/wbr_back.sv
// Back end: marks out-of-order runs, scans released slots and drives the result register.
module wbr_back import wbr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PTR_W-1:0]  rsp_release_pointer,
   output logic              rsp_advanced,
   output logic              rsp_double_mark
);

   state_type               state_ff, state_in;
   logic                    marks_mem [SLOT_COUNT];
   logic                    mark_rd_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [PTR_W-1:0]        pos_ff, pos_in;
   logic [PTR_W-1:0]        limit_ff, limit_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic                    adv_ff, adv_in;
   logic                    dbl_ff, dbl_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]        rsp_ptr_ff;
   logic                    rsp_adv_ff;
   logic                    rsp_dbl_ff;
   logic                    in_order;
   logic                    scan_go;
   logic                    out_free;
   logic                    rsp_load;
   logic                    mark_we;
   logic                    mark_val;

   assign in_order = (q_item.start_slot == ptr_ff[SLOT_W-1:0]);
   assign scan_go  = (pos_ff != limit_ff) && mark_rd_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               if (in_order) begin
                  state_in = ST_SCAN;
               end else if (q_item.len_zero) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            if (cnt_ff == LEN_W'(1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (!scan_go) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and datapath updates
   always_comb begin
      q_pop    = 1'b0;
      mark_we  = 1'b0;
      mark_val = 1'b0;
      rsp_load = 1'b0;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      limit_in = limit_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      adv_in   = adv_ff;
      dbl_in   = dbl_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mark_we  = 1'b1;
            mark_val = 1'b0;
            idx_in   = IDX_W'(idx_ff + 1'b1);
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               limit_in = q_item.producer_limit;
               dbl_in   = 1'b0;
               adv_in   = in_order;
               cnt_in   = q_item.run_length;
               pos_in   = ptr_ff + PTR_W'(q_item.run_length);
               if (in_order) begin
                  idx_in = pos_in[IDX_W-1:0];
               end else begin
                  idx_in = q_item.start_slot[IDX_W-1:0];
               end
            end
         end
         ST_MARK: begin
            mark_we  = 1'b1;
            mark_val = 1'b1;
            if (mark_rd_ff) begin
               dbl_in = 1'b1;
            end
            idx_in = IDX_W'(idx_ff + 1'b1);
            cnt_in = LEN_W'(cnt_ff - 1'b1);
         end
         ST_SCAN: begin
            if (scan_go) begin
               mark_we  = 1'b1;
               mark_val = 1'b0;
               pos_in   = PTR_W'(pos_ff + 1'b1);
               idx_in   = IDX_W'(idx_ff + 1'b1);
            end else begin
               ptr_in = pos_ff;
            end
         end
         ST_RESULT: begin
            rsp_load = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      // fetch the mark of the slot handled next cycle
      rd_addr = idx_in;
   end

   // Write one mark and read the next one per cycle
   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks_mem[idx_ff] <= mark_val;
      end
      mark_rd_ff <= marks_mem[rd_addr];
   end

   // Hold result until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      limit_ff <= limit_in;
      cnt_ff   <= cnt_in;
      adv_ff   <= adv_in;
      dbl_ff   <= dbl_in;
      if (rsp_load) begin
         rsp_ptr_ff <= ptr_ff;
         rsp_adv_ff <= adv_ff;
         rsp_dbl_ff <= dbl_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_release_pointer = rsp_ptr_ff;
   assign rsp_advanced        = rsp_adv_ff;
   assign rsp_double_mark     = rsp_dbl_ff;

endmodule

FILE: tb/tb_write_buffer_in_order_release_unit.sv
// Self-checking testbench for the write buffer in-order release unit.
module tb_write_buffer_in_order_release_unit import wbr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected result beat
   typedef struct {
      logic [PTR_W-1:0] release_pointer;
      logic             advanced;
      logic             double_mark;
   } release_result_type;

   // Tracks the release pointer and done marks, and holds the results still owed
   class release_tracker;
      logic [PTR_W-1:0]   rel_ptr;
      bit                 done_mark [SLOT_COUNT];
      release_result_type owed_q [$];
      int                 mismatches;
      int                 checked;
      int                 in_order_runs;
      int                 double_marks;

      function new();
         rel_ptr = '0;
         foreach (done_mark[i]) done_mark[i] = 1'b0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // Apply one accepted run and queue the result it owes
      function void note_run(logic [SLOT_W-1:0] start, logic [LEN_W-1:0] len,
                             logic [PTR_W-1:0] limit);
         release_result_type r;
         logic [PTR_W-1:0]   pos;
         logic [IDX_W-1:0]   ix;
         r.advanced    = 1'b0;
         r.double_mark = 1'b0;
         if (start == rel_ptr[SLOT_W-1:0]) begin
            // skip the run, then release marked slots up to the limit
            pos = rel_ptr + len;
            while (pos != limit && done_mark[pos[IDX_W-1:0]]) begin
               done_mark[pos[IDX_W-1:0]] = 1'b0;
               pos++;
            end
            rel_ptr    = pos;
            r.advanced = 1'b1;
            in_order_runs++;
         end else begin
            // mark the run, wrapping round the store
            for (int i = 0; i < len; i++) begin
               ix = IDX_W'(int'(start) + i);
               if (done_mark[ix]) r.double_mark = 1'b1;
               done_mark[ix] = 1'b1;
            end
            if (r.double_mark) double_marks++;
         end
         r.release_pointer = rel_ptr;
         owed_q.push_back(r);
      endfunction

      // Compare one result beat with the oldest owed result
      function void check_result(logic [PTR_W-1:0] ptr, logic adv, logic dbl);
         release_result_type e;
         if (owed_q.size() == 0) begin
            flag($sformatf("unexpected result: ptr=%h adv=%b dbl=%b", ptr, adv, dbl));
            return;
         end
         e = owed_q.pop_front();
         checked++;
         if (ptr !== e.release_pointer || adv !== e.advanced || dbl !== e.double_mark)
            flag($sformatf("result %0d: expected ptr=%h adv=%b dbl=%b, got ptr=%h adv=%b dbl=%b",
                           checked, e.release_pointer, e.advanced, e.double_mark,
                           ptr, adv, dbl));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [SLOT_W-1:0] req_start_slot;
   logic [LEN_W-1:0]  req_run_length;
   logic [PTR_W-1:0]  req_producer_limit;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PTR_W-1:0]  rsp_release_pointer;
   logic              rsp_advanced;
   logic              rsp_double_mark;

   release_tracker tracker = new();
   bit             idle_on = 1'b1;
   int             beats_sent = 0;
   int             stall_left = 0;

   write_buffer_in_order_release_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_slot     (req_start_slot),
      .req_run_length     (req_run_length),
      .req_producer_limit (req_producer_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_release_pointer(rsp_release_pointer),
      .rsp_advanced       (rsp_advanced),
      .rsp_double_mark    (rsp_double_mark)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_release_pointer, rsp_advanced, rsp_double_mark);
   end

   // Drive one run and hold it until the beat is taken
   task automatic send_run(input logic [SLOT_W-1:0] start, input logic [LEN_W-1:0] len,
                           input logic [PTR_W-1:0] limit);
      int gap;
      idle_on = (beats_sent < 300 || beats_sent >= 380) && beats_sent < 650;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_start_slot     <= start;
      req_run_length     <= len;
      req_producer_limit <= limit;
      do @(posedge clock); while (req_stall);
      tracker.note_run(start, len, limit);
      beats_sent++;
   endtask

   // Complete a window ahead of the release pointer in shuffled runs
   task automatic send_window();
      logic [PTR_W-1:0] base;
      logic [PTR_W-1:0] limit;
      int               width;
      int               off;
      int               l;
      int               j;
      int               k;
      int               pick;
      int               tmp;
      int               run_off [$];
      int               run_len [$];
      base  = tracker.rel_ptr;
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      off   = 0;
      while (off < width) begin
         l = $urandom_range(1, 4);
         if (l > width - off) l = width - off;
         run_off.push_back(off);
         run_len.push_back(l);
         off += l;
      end
      // add an empty run now and then, and a repeated run for double marks
      if ($urandom_range(0, 9) == 0) begin
         run_off.push_back($urandom_range(0, width));
         run_len.push_back(0);
      end
      if ($urandom_range(0, 7) == 0) begin
         k = $urandom_range(0, run_off.size() - 1);
         run_off.push_back(run_off[k]);
         run_len.push_back(run_len[k]);
      end
      // limit at the window end mostly, sometimes short, long, behind or random
      pick = $urandom_range(0, 9);
      if (pick < 6)       limit = base + width;
      else if (pick == 6) limit = base + $urandom_range(0, width);
      else if (pick == 7) limit = base + width + $urandom_range(1, 20);
      else if (pick == 8) limit = base - $urandom_range(1, 8);
      else                limit = $urandom;
      for (j = run_off.size() - 1; j > 0; j--) begin
         k          = $urandom_range(0, j);
         tmp        = run_off[j];
         run_off[j] = run_off[k];
         run_off[k] = tmp;
         tmp        = run_len[j];
         run_len[j] = run_len[k];
         run_len[k] = tmp;
      end
      for (j = 0; j < run_off.size(); j++)
         send_run(SLOT_W'(base + run_off[j]), LEN_W'(run_len[j]), limit);
   endtask

   // Main sequence
   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_start_slot     <= '0;
      req_run_length     <= '0;
      req_producer_limit <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty runs, marks, double marks, limit stops, full-store runs
      send_run(16'h0000, 9'd0, 32'h0000_0000);
      send_run(16'd5, 9'd3, 32'hFFFF_FFFF);
      send_run(16'd6, 9'd1, 32'hFFFF_FFFF);
      send_run(16'd100, 9'd0, 32'h0000_0000);
      send_run(16'd0, 9'd5, 32'd100);
      send_run(16'd12, 9'd4, 32'h0000_0000);
      send_run(16'd10, 9'd2, 32'h0000_0000);
      send_run(16'd8, 9'd2, 32'd13);
      send_run(16'd13, 9'd0, 32'h0000_0000);
      send_run(16'hFFFF, 9'd256, 32'h0000_0000);
      send_run(16'h1234, 9'd256, 32'h0000_0000);
      send_run(16'd16, 9'd256, 32'd5);
      send_run(tracker.rel_ptr[SLOT_W-1:0], 9'd256, tracker.rel_ptr + 256);
      send_run(16'hFFFF, 9'd1, 32'hFFFF_FFFF);
      send_run(tracker.rel_ptr[SLOT_W-1:0] ^ 16'h8000, 9'd1, 32'h0000_0000);
      send_run(tracker.rel_ptr[SLOT_W-1:0], 9'd0, 32'hFFFF_FFFF);

      // random: mostly well-formed windows, some noise runs
      while (beats_sent < 750) begin
         if ($urandom_range(0, 3) != 0)
            send_window();
         else
            send_run(SLOT_W'($urandom),
                     ($urandom_range(0, 15) == 0) ? LEN_W'($urandom_range(0, 256))
                                                  : LEN_W'($urandom_range(0, 8)),
                     $urandom);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then let any stray beat show up
      while (tracker.owed_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (tracker.owed_q.size() != 0)
         tracker.flag($sformatf("%0d results never arrived", tracker.owed_q.size()));

      $display("Run covered %0d runs: %0d in order, %0d with double marks, %0d results checked.",
               beats_sent, tracker.in_order_runs, tracker.double_marks, tracker.checked);
      $display("Final release pointer %h, %0d mismatches.", tracker.rel_ptr,
               tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog
   initial begin
      #12_000_000;
      $display("Timeout with %0d results outstanding.", tracker.owed_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
